// ===== rtl/pvs_pkg.sv =====
// Package for the planar video scanout unit: frame geometry, memory sizing,
// codes and the queue transaction type. No dependencies.
`timescale 1ns / 1ps
package pvs_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 200;
    localparam int ADDR_BITS    = 16;

    localparam int MEM_DEPTH    = 1 << ADDR_BITS;
    localparam int NUM_PLANES   = 4;
    localparam int PLANE_W      = 2;
    localparam int BYTE_W       = 8;
    localparam int BIT_POS_W    = 3;
    localparam int COL_W        = $clog2(FRAME_WIDTH + 1);
    localparam int ROW_W        = $clog2(FRAME_HEIGHT + 1);

    localparam int WR_ADDR_W    = 16;
    localparam int SCAN_START_W = 16;
    localparam int PAL_ENTRY_W  = 6;
    localparam int PAL_HALF_W   = 48;
    localparam int PAL_W        = 2 * PAL_HALF_W;
    localparam int INDEX_W      = 4;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 48;

    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [PAL_HALF_W-1:0] PAL_LOW_RESET  = 48'd32166151725120;
    localparam logic [PAL_HALF_W-1:0] PAL_HIGH_RESET = 48'd281404058349176;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_TICK  = 1'b1
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCAN_START   = 2'd0,
        CFG_PALETTE_LOW  = 2'd1,
        CFG_PALETTE_HIGH = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_kind                  kind;
        logic [ADDR_BITS-1:0]   addr;
        logic [PLANE_W-1:0]     plane;
        logic [BYTE_W-1:0]      data;
        logic [BIT_POS_W-1:0]   bit_sel;
        logic                   line_end;
        logic                   frame_end;
    } t_q_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/pvs_front.sv =====
// Front end: accepts transactions, keeps the scan counters and turns each
// tick into a memory read request. Depends on pvs_pkg.
`timescale 1ns / 1ps
module pvs_front
    import pvs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_kind,
    input  logic [WR_ADDR_W-1:0]    i_write_address,
    input  logic [PLANE_W-1:0]      i_write_plane,
    input  logic [BYTE_W-1:0]       i_write_data,
    input  logic [SCAN_START_W-1:0] i_scan_start,
    output logic                    o_push,
    output t_q_entry                o_entry
);

    logic [ADDR_BITS-1:0] r_scan_addr, n_scan_addr;
    logic [BIT_POS_W-1:0] r_bit_pos, n_bit_pos;
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_W-1:0]     r_row, n_row;
    logic                 last_col;
    logic                 last_row;
    logic                 is_tick;

    assign is_tick  = (t_kind'(i_kind) == KIND_TICK);
    assign last_col = (r_col == COL_W'(FRAME_WIDTH - 1));
    assign last_row = (r_row == ROW_W'(FRAME_HEIGHT - 1));

    always_comb begin
        n_scan_addr = r_scan_addr;
        n_bit_pos   = r_bit_pos;
        n_col       = r_col;
        n_row       = r_row;
        if (i_accept && is_tick) begin
            n_bit_pos = r_bit_pos + 1'b1;
            if (r_bit_pos == '1) begin
                n_scan_addr = r_scan_addr + 1'b1;
            end
            if (last_col && last_row) begin
                n_scan_addr = ADDR_BITS'(i_scan_start);
                n_bit_pos   = '0;
                n_col       = '0;
                n_row       = '0;
            end else if (last_col) begin
                n_bit_pos = '0;
                n_col     = '0;
                n_row     = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= ADDR_BITS'(SCAN_START_W'(0));
            r_bit_pos   <= '0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            r_scan_addr <= n_scan_addr;
            r_bit_pos   <= n_bit_pos;
            r_col       <= n_col;
            r_row       <= n_row;
        end
    end

    always_comb begin
        o_push            = i_accept;
        o_entry.kind      = t_kind'(i_kind);
        o_entry.plane     = i_write_plane;
        o_entry.data      = i_write_data;
        o_entry.bit_sel   = BIT_POS_W'(7) - r_bit_pos;
        o_entry.line_end  = last_col;
        o_entry.frame_end = last_col && last_row;
        if (is_tick) begin
            o_entry.addr = r_scan_addr;
        end else begin
            o_entry.addr = ADDR_BITS'(i_write_address);
        end
    end

endmodule

// ===== rtl/pvs_queue.sv =====
// Short transaction queue between front end and back end.
// Depends on pvs_pkg.
`timescale 1ns / 1ps
module pvs_queue
    import pvs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_entry,
    output t_q_status o_status
);

    t_q_entry             r_slots [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_entry        = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/pvs_back.sv =====
// Back end: plane memories, pixel bit select, palette lookup and the output
// register. Depends on pvs_pkg.
`timescale 1ns / 1ps
module pvs_back
    import pvs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_q_entry               i_entry,
    input  t_q_status              i_q_status,
    output logic                   o_pop,
    input  logic [PAL_W-1:0]       i_palette,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PAL_ENTRY_W-1:0] o_pixel_color,
    output logic                   o_line_end,
    output logic                   o_frame_end
);

    logic                   advance;
    logic                   wr_en;
    logic                   rd_en;
    logic [BYTE_W-1:0]      r_rd_data [NUM_PLANES];

    logic                   r_s1_valid;
    logic [BIT_POS_W-1:0]   r_s1_bit_sel;
    logic                   r_s1_line_end;
    logic                   r_s1_frame_end;

    logic                   r_out_valid;
    logic [PAL_ENTRY_W-1:0] r_pixel_color;
    logic                   r_line_end;
    logic                   r_frame_end;

    logic [INDEX_W-1:0]     pix_index;
    logic [PAL_ENTRY_W-1:0] pix_color;

    assign advance = !r_out_valid || !i_stall;
    assign o_pop   = advance && !i_q_status.empty;
    assign wr_en   = o_pop && (i_entry.kind == KIND_WRITE);
    assign rd_en   = o_pop && (i_entry.kind == KIND_TICK);

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        logic [BYTE_W-1:0] r_mem [MEM_DEPTH];

        always_ff @(posedge i_clk) begin
            if (wr_en && (i_entry.plane == PLANE_W'(p))) begin
                r_mem[i_entry.addr] <= i_entry.data;
            end
            if (rd_en) begin
                r_rd_data[p] <= r_mem[i_entry.addr];
            end
        end

        assign pix_index[p] = r_rd_data[p][r_s1_bit_sel];
    end

    assign pix_color = i_palette[PAL_ENTRY_W * int'(pix_index) +: PAL_ENTRY_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= rd_en;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_bit_sel   <= i_entry.bit_sel;
            r_s1_line_end  <= i_entry.line_end;
            r_s1_frame_end <= i_entry.frame_end;
            r_pixel_color  <= pix_color;
            r_line_end     <= r_s1_line_end;
            r_frame_end    <= r_s1_frame_end;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_color = r_pixel_color;
    assign o_line_end    = r_line_end;
    assign o_frame_end   = r_frame_end;

endmodule

// ===== rtl/planar_video_scanout_unit.sv =====
// Planar video scanout unit top level: configuration registers, front end,
// transaction queue and back end. Depends on pvs_pkg, pvs_front, pvs_queue, pvs_back.
// A tick passes the queue, the plane memory read and the output register to o_valid.
// Throughput: one transaction per cycle unless o_stall or i_stall holds the flow; the
// plane memory port takes one access a cycle. Reset: synchronous; clears scan counters,
// queue, pipeline valids and loads register defaults. Plane memory is not cleared.
`timescale 1ns / 1ps
module planar_video_scanout_unit
    import pvs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_kind,
    input  logic [WR_ADDR_W-1:0]   i_write_address,
    input  logic [PLANE_W-1:0]     i_write_plane,
    input  logic [BYTE_W-1:0]      i_write_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PAL_ENTRY_W-1:0] o_pixel_color,
    output logic                   o_line_end,
    output logic                   o_frame_end,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [SCAN_START_W-1:0] r_scan_start;
    logic [PAL_HALF_W-1:0]   r_pal_low;
    logic [PAL_HALF_W-1:0]   r_pal_high;

    logic      accept;
    logic      push;
    logic      pop;
    t_q_entry  front_entry;
    t_q_entry  queue_entry;
    t_q_status q_status;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_status.full;
    assign accept      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_start <= '0;
            r_pal_low    <= PAL_LOW_RESET;
            r_pal_high   <= PAL_HIGH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCAN_START:   r_scan_start <= i_cfg_data[SCAN_START_W-1:0];
                CFG_PALETTE_LOW:  r_pal_low    <= i_cfg_data[PAL_HALF_W-1:0];
                CFG_PALETTE_HIGH: r_pal_high   <= i_cfg_data[PAL_HALF_W-1:0];
                default:          r_scan_start <= r_scan_start;
            endcase
        end
    end

    pvs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_kind          (i_kind),
        .i_write_address (i_write_address),
        .i_write_plane   (i_write_plane),
        .i_write_data    (i_write_data),
        .i_scan_start    (r_scan_start),
        .o_push          (push),
        .o_entry         (front_entry)
    );

    pvs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (queue_entry),
        .o_status (q_status)
    );

    pvs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (queue_entry),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .i_palette     ({r_pal_high, r_pal_low}),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_color (o_pixel_color),
        .o_line_end    (o_line_end),
        .o_frame_end   (o_frame_end)
    );

`ifndef SYNTHESIS
    a_frame_end_on_line_end: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_line_end
    ) else $error("frame end without line end");

    a_queue_status: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty)
    ) else $error("queue both full and empty");

    a_pop_needs_entry: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty
    ) else $error("pop from empty queue");

    a_no_output_after_reset: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid
    ) else $error("output valid right after reset");
`endif

endmodule

// ===== sim/planar_video_scanout_unit_test.sv =====
// Self-checking testbench for planar_video_scanout_unit: drives plane writes and
// pixel ticks, predicts every pixel in a scoreboard class and checks the results.
// Depends on pvs_pkg and the planar_video_scanout_unit RTL.
`timescale 1ns / 1ps
module planar_video_scanout_unit_test;
    import pvs_pkg::*;

    localparam int                     RANDOM_PER_PHASE   = 400;
    localparam int                     WATCHDOG_LIMIT     = 5000;
    localparam int                     HOLD_OFF_CYCLES    = 400;
    localparam int                     SETTLE_CYCLES      = 8;
    localparam int                     REPORT_LIMIT       = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_INDEX = 2'd3;

    typedef struct packed {
        logic [PAL_ENTRY_W-1:0] color;
        logic                   line_end;
        logic                   frame_end;
    } t_pixel;

    class pixel_scoreboard;
        bit [31:0]             plane_mem   [MEM_DEPTH];
        bit [NUM_PLANES-1:0]   plane_known [MEM_DEPTH];
        bit [SCAN_START_W-1:0] scan_start;
        bit [PAL_HALF_W-1:0]   pal_low;
        bit [PAL_HALF_W-1:0]   pal_high;
        bit [ADDR_BITS-1:0]    scan_addr;
        bit [BIT_POS_W-1:0]    bit_pos;
        int unsigned           column;
        int unsigned           row;
        int unsigned           failures;
        t_pixel                expected_pixels [$];

        function new();
            scan_start  = '0;
            pal_low     = PAL_LOW_RESET;
            pal_high    = PAL_HIGH_RESET;
            scan_addr   = '0;
            bit_pos     = '0;
            column      = 0;
            row         = 0;
            failures    = 0;
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SCAN_START:   scan_start = value[SCAN_START_W-1:0];
                CFG_PALETTE_LOW:  pal_low    = value;
                CFG_PALETTE_HIGH: pal_high   = value;
                default: ;
            endcase
        endfunction

        function void note_transaction(t_kind kind, logic [WR_ADDR_W-1:0] addr,
                                       logic [PLANE_W-1:0] plane, logic [BYTE_W-1:0] data);
            bit [31:0]          word;
            bit [PAL_W-1:0]     palette;
            bit [INDEX_W-1:0]   idx;
            int                 sel;
            bit                 last_col;
            bit                 last_row;
            t_pixel             px;
            if (kind == KIND_WRITE) begin
                plane_mem[addr][plane*BYTE_W +: BYTE_W] = data;
                plane_known[addr][plane] = 1'b1;
                return;
            end
            word = plane_mem[scan_addr];
            sel  = 7 - bit_pos;
            for (int p = 0; p < NUM_PLANES; p++)
                idx[p] = word[p*BYTE_W + sel];
            palette      = {pal_high, pal_low};
            last_col     = (column + 1 >= FRAME_WIDTH);
            last_row     = (row + 1 >= FRAME_HEIGHT);
            px.color     = palette[idx*PAL_ENTRY_W +: PAL_ENTRY_W];
            px.line_end  = last_col;
            px.frame_end = last_col && last_row;
            expected_pixels.push_back(px);

            bit_pos = bit_pos + 1'b1;
            if (bit_pos == 0)
                scan_addr = scan_addr + 1'b1;
            if (px.frame_end) begin
                scan_addr = scan_start;
                bit_pos   = '0;
                column    = 0;
                row       = 0;
            end else if (last_col) begin
                bit_pos = '0;
                column  = 0;
                row++;
            end else begin
                column++;
            end
        endfunction

        function void check_pixel(t_pixel seen);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected pixel: color %0d line_end %b frame_end %b",
                             seen.color, seen.line_end, seen.frame_end);
                return;
            end
            want = expected_pixels.pop_front();
            if (seen.color !== want.color || seen.line_end !== want.line_end ||
                seen.frame_end !== want.frame_end) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"pixel mismatch: expected color %0d line_end %b frame_end %b,",
                              " got color %0d line_end %b frame_end %b"},
                             want.color, want.line_end, want.frame_end,
                             seen.color, seen.line_end, seen.frame_end);
            end
        endfunction
    endclass

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_valid         = 1'b0;
    logic                   o_stall;
    logic                   i_kind          = 1'b0;
    logic [WR_ADDR_W-1:0]   i_write_address = '0;
    logic [PLANE_W-1:0]     i_write_plane   = '0;
    logic [BYTE_W-1:0]      i_write_data    = '0;
    logic                   o_valid;
    logic                   i_stall         = 1'b0;
    logic [PAL_ENTRY_W-1:0] o_pixel_color;
    logic                   o_line_end;
    logic                   o_frame_end;
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;

    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    bit              hold_request  = 1'b0;
    pixel_scoreboard sb            = new();

    planar_video_scanout_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_write_address (i_write_address),
        .i_write_plane   (i_write_plane),
        .i_write_data    (i_write_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_color   (o_pixel_color),
        .o_line_end      (o_line_end),
        .o_frame_end     (o_frame_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
                i_stall      <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin : monitor
        int unsigned quiet_cycles;
        t_pixel      seen;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
                seen.color     = o_pixel_color;
                seen.line_end  = o_line_end;
                seen.frame_end = o_frame_end;
                sb.check_pixel(seen);
            end
            if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) ||
                (i_cfg_valid && o_cfg_ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(t_kind kind, logic [WR_ADDR_W-1:0] addr,
                             logic [PLANE_W-1:0] plane, logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_write_address <= addr;
        i_write_plane   <= plane;
        i_write_data    <= data;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_transaction(kind, addr, plane, data);
    endtask

    // fill any plane byte of the scan word that was never written, then tick
    task automatic send_tick();
        logic [ADDR_BITS-1:0] addr;
        addr = sb.scan_addr;
        for (int p = 0; p < NUM_PLANES; p++)
            if (!sb.plane_known[addr][p])
                send_item(KIND_WRITE, WR_ADDR_W'(addr), PLANE_W'(p), BYTE_W'($urandom));
        send_item(KIND_TICK, WR_ADDR_W'($urandom), PLANE_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic send_random_item();
        logic [WR_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]    data;
        if ($urandom_range(99) < 55) begin
            send_tick();
        end else begin
            case ($urandom_range(9))
                0:          addr = '0;
                1:          addr = '1;
                2, 3, 4, 5: addr = WR_ADDR_W'(sb.scan_addr + $urandom_range(3));
                default:    addr = WR_ADDR_W'($urandom);
            endcase
            case ($urandom_range(7))
                0:       data = '0;
                1:       data = '1;
                default: data = BYTE_W'($urandom);
            endcase
            send_item(KIND_WRITE, addr, PLANE_W'($urandom), data);
        end
    endtask

    task automatic drain_pixels();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic settle();
        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.set_register(idx, value);
    endtask

    initial begin : stimulus
        send_idle_pct = 31;
        recv_idle_pct = 74;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-hot bytes walk the index bits, then a word of all ones
        for (int p = 0; p < NUM_PLANES; p++)
            send_item(KIND_WRITE, 16'h0000, PLANE_W'(p), 8'h80 >> p);
        for (int p = 0; p < NUM_PLANES; p++)
            send_item(KIND_WRITE, 16'h0001, PLANE_W'(p), 8'hff);
        send_item(KIND_WRITE, 16'hffff, 2'd3, 8'h00);
        repeat (16) send_tick();

        repeat (RANDOM_PER_PHASE / 2) send_random_item();
        drain_pixels();
        repeat (RANDOM_PER_PHASE / 2) send_random_item();

        settle();
        write_register(CFG_SCAN_START, '0);
        write_register(CFG_PALETTE_LOW, '0);
        write_register(CFG_PALETTE_HIGH, '1);
        write_register(CFG_RESERVED_INDEX, CFG_DATA_W'({$urandom, $urandom}));
        send_idle_pct = 74;
        recv_idle_pct = 31;
        repeat (RANDOM_PER_PHASE) send_random_item();

        settle();
        write_register(CFG_SCAN_START, CFG_DATA_W'(16'hffff));
        write_register(CFG_PALETTE_LOW, CFG_DATA_W'({$urandom, $urandom}));
        write_register(CFG_PALETTE_HIGH, CFG_DATA_W'({$urandom, $urandom}));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (RANDOM_PER_PHASE) send_random_item();

        settle();
        write_register(CFG_SCAN_START, CFG_DATA_W'($urandom));
        write_register(CFG_PALETTE_LOW, '1);
        write_register(CFG_PALETTE_HIGH, '0);
        repeat (100) send_random_item();

        settle();
        repeat (20) @(posedge i_clk);
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pvs_pkg.sv
rtl/pvs_front.sv
rtl/pvs_queue.sv
rtl/pvs_back.sv
rtl/planar_video_scanout_unit.sv
sim/planar_video_scanout_unit_test.sv
